// File: sv/sbus_frame_decoder_core_macros.svh
// Assertion macros for the SBUS frame decoder.
// The surrounding module must provide clk_i and rst_ni.
`ifndef SBUS_FRAME_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: sv/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int unsigned DATA_LEN     = 23;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned CH_N         = 10;
  localparam int unsigned CH_W         = 11;
  localparam int unsigned STICK_W      = 16;
  localparam int unsigned MS_W         = 14;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 112;

  localparam logic [7:0]         HEADER      = 8'h0F;
  localparam logic [7:0]         FOOTER      = 8'h00;
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(DATA_LEN);
  localparam logic [STICK_W-1:0] STICK_MID   = 16'd1000;
  localparam logic [STICK_W-1:0] DZ_WIDE_LO  = 16'd950;
  localparam logic [STICK_W-1:0] DZ_WIDE_HI  = 16'd1060;
  localparam logic [STICK_W-1:0] DZ_S1_LO    = 16'd996;
  localparam logic [STICK_W-1:0] DZ_S1_HI    = 16'd1004;
  localparam logic [STICK_W-1:0] DZ_S2_LO    = 16'd994;
  localparam logic [STICK_W-1:0] DZ_S2_HI    = 16'd1002;
  localparam logic [CH_W-1:0]    SW_LOW_LIM  = 11'd500;
  localparam logic [CH_W-1:0]    SW_MID_LO   = 11'd600;
  localparam logic [CH_W-1:0]    SW_MID_HI   = 11'd1200;
  localparam logic [CH_W-1:0]    KNOB_RESET  = 11'd200;
  localparam logic [MS_W-1:0]    MS_MAX      = 14'd10000;
  localparam logic [MS_W-1:0]    MS_RESET    = 14'd1000;
  localparam logic [MS_W-1:0]    TIMEOUT_RST = 14'd1500;
  localparam logic [7:0]         LOST_RST    = 8'd10;
  localparam logic [7:0]         LOST_MAX    = 8'd255;

  localparam logic [1:0] SW_POS1 = 2'd1;
  localparam logic [1:0] SW_POS2 = 2'd2;
  localparam logic [1:0] SW_POS3 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET0    = 3'd0,
    REG_OFFSET1    = 3'd1,
    REG_OFFSET2    = 3'd2,
    REG_OFFSET3    = 3'd3,
    REG_TIMEOUT    = 3'd4,
    REG_LOST_LIMIT = 3'd5
  } sfd_reg_e;

  // Collector to mapper: decoded channels of the stored frame.
  typedef struct packed {
    logic                     ok;
    logic [7:0]               flags;
    logic [CH_N-1:0][CH_W-1:0] ch;
  } sfd_frame_t;

  // Result payload, stick0 in the lowest bits.
  typedef struct packed {
    logic [1:0]         online;
    logic [1:0]         sw3;
    logic [1:0]         sw2;
    logic [1:0]         sw1;
    logic [CH_W-1:0]    knob3;
    logic [CH_W-1:0]    knob2;
    logic [CH_W-1:0]    knob1;
    logic [STICK_W-1:0] stick3;
    logic [STICK_W-1:0] stick2;
    logic [STICK_W-1:0] stick1;
    logic [STICK_W-1:0] stick0;
  } sfd_res_t;

  function automatic logic [STICK_W-1:0] snap(input logic [CH_W-1:0] raw,
                                             input logic [STICK_W-1:0] off,
                                             input logic [STICK_W-1:0] lo,
                                             input logic [STICK_W-1:0] hi);
    logic [STICK_W-1:0] v;
    v = {{(STICK_W-CH_W){1'b0}}, raw} + off;
    if (v > lo && v < hi) begin
      return STICK_MID;
    end
    return v;
  endfunction

endpackage

// File: sv/sfd_collect.sv
`timescale 1ns / 1ps
module sfd_collect
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output sfd_frame_t frame_o
);

  logic             hunting_q, hunting_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       frame_q [DATA_LEN];
  logic             store;

  always_comb begin
    hunting_d = hunting_q;
    idx_d     = idx_q;
    store     = 1'b0;
    if (hunting_q) begin
      if (byte_i == HEADER) begin
        hunting_d = 1'b0;
        idx_d     = '0;
      end
    end else if (idx_q < LAST_IDX) begin
      store = 1'b1;
      idx_d = idx_q + 1'b1;
    end else begin
      hunting_d = 1'b1;
      idx_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      idx_q     <= '0;
    end else if (en_i) begin
      hunting_q <= hunting_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store) begin
      frame_q[idx_q] <= byte_i;
    end
  end

  // standard SBUS packing, byte n of the frame at frame_q[n-1]
  always_comb begin
    frame_o.ok    = !hunting_q && (idx_q == LAST_IDX) && (byte_i == FOOTER);
    frame_o.flags = frame_q[22];
    frame_o.ch[0] = {frame_q[1][2:0], frame_q[0]};
    frame_o.ch[1] = {frame_q[2][5:0], frame_q[1][7:3]};
    frame_o.ch[2] = {frame_q[4][0],   frame_q[3], frame_q[2][7:6]};
    frame_o.ch[3] = {frame_q[5][3:0], frame_q[4][7:1]};
    frame_o.ch[4] = {frame_q[6][6:0], frame_q[5][7:4]};
    frame_o.ch[5] = {frame_q[8][1:0], frame_q[7], frame_q[6][7]};
    frame_o.ch[6] = {frame_q[9][4:0], frame_q[8][7:2]};
    frame_o.ch[7] = {frame_q[10],     frame_q[9][7:5]};
    frame_o.ch[8] = {frame_q[12][2:0], frame_q[11]};
    frame_o.ch[9] = {frame_q[13][5:0], frame_q[12][7:3]};
  end

endmodule

// File: sv/sfd_map.sv
`timescale 1ns / 1ps
module sfd_map
  import sfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  en_i,
  input  logic                  tick_i,
  input  sfd_frame_t            frame_i,
  output logic                  res_valid_o,
  output sfd_res_t              res_o
);

  logic [3:0][STICK_W-1:0] offset_q;
  logic [MS_W-1:0]         timeout_q;
  logic [7:0]              lost_limit_q;

  logic [3:0][STICK_W-1:0] stick_q, stick_d;
  logic [2:0][CH_W-1:0]    knob_q, knob_d;
  logic [2:0][1:0]         sw_q, sw_d;
  logic                    flag_q, flag_d;
  logic [7:0]              lost_q, lost_d, lost_inc;
  logic [MS_W-1:0]         ms_q, ms_d;
  logic                    frame_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      timeout_q    <= TIMEOUT_RST;
      lost_limit_q <= LOST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET0:    offset_q[0]  <= cfg_data_i;
        REG_OFFSET1:    offset_q[1]  <= cfg_data_i;
        REG_OFFSET2:    offset_q[2]  <= cfg_data_i;
        REG_OFFSET3:    offset_q[3]  <= cfg_data_i;
        REG_TIMEOUT:    timeout_q    <= cfg_data_i[MS_W-1:0];
        REG_LOST_LIMIT: lost_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign frame_hit   = !tick_i && frame_i.ok;
  assign res_valid_o = tick_i || frame_hit;
  assign lost_inc    = (lost_q == LOST_MAX) ? lost_q : lost_q + 8'd1;

  always_comb begin
    stick_d = stick_q;
    knob_d  = knob_q;
    sw_d    = sw_q;
    flag_d  = flag_q;
    lost_d  = lost_q;
    ms_d    = ms_q;
    if (tick_i) begin
      if (ms_q < MS_MAX) begin
        ms_d = ms_q + 1'b1;
      end
    end else if (frame_hit) begin
      stick_d[0] = snap(frame_i.ch[3], offset_q[0], DZ_WIDE_LO, DZ_WIDE_HI);
      stick_d[1] = snap(frame_i.ch[2], offset_q[1], DZ_S1_LO, DZ_S1_HI);
      stick_d[2] = snap(frame_i.ch[0], offset_q[2], DZ_S2_LO, DZ_S2_HI);
      stick_d[3] = snap(frame_i.ch[1], offset_q[3], DZ_WIDE_LO, DZ_WIDE_HI);
      knob_d[0]  = frame_i.ch[5];
      knob_d[1]  = frame_i.ch[7];
      knob_d[2]  = frame_i.ch[6];
      sw_d[0]    = (frame_i.ch[9] < SW_LOW_LIM) ? SW_POS1 : SW_POS2;
      sw_d[1]    = (frame_i.ch[8] < SW_LOW_LIM) ? SW_POS1 : SW_POS2;
      if (frame_i.ch[4] < SW_LOW_LIM) begin
        sw_d[2] = SW_POS1;
      end else if (frame_i.ch[4] > SW_MID_LO && frame_i.ch[4] < SW_MID_HI) begin
        sw_d[2] = SW_POS2;
      end else begin
        sw_d[2] = SW_POS3;
      end
      if (frame_i.flags == 8'd0) begin
        flag_d = 1'b1;
        lost_d = '0;
      end else begin
        lost_d = lost_inc;
        if (lost_inc > lost_limit_q) begin
          flag_d = 1'b0;
        end
      end
      ms_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_q <= {4{STICK_MID}};
      knob_q  <= {3{KNOB_RESET}};
      sw_q    <= {SW_POS2, SW_POS1, SW_POS1};
      flag_q  <= 1'b0;
      lost_q  <= '0;
      ms_q    <= MS_RESET;
    end else if (en_i) begin
      stick_q <= stick_d;
      knob_q  <= knob_d;
      sw_q    <= sw_d;
      flag_q  <= flag_d;
      lost_q  <= lost_d;
      ms_q    <= ms_d;
    end
  end

  always_comb begin
    res_o.stick0 = stick_d[0];
    res_o.stick1 = stick_d[1];
    res_o.stick2 = stick_d[2];
    res_o.stick3 = stick_d[3];
    res_o.knob1  = knob_d[0];
    res_o.knob2  = knob_d[1];
    res_o.knob3  = knob_d[2];
    res_o.sw1    = sw_d[0];
    res_o.sw2    = sw_d[1];
    res_o.sw3    = sw_d[2];
    res_o.online = {ms_d < timeout_q, flag_d};
  end

endmodule

// File: sv/sbus_frame_decoder_core.sv
`timescale 1ns / 1ps
// SBUS frame decoder.
// Slave stream: one transfer per received UART byte (tuser = 0, tdata = byte)
// or per one-millisecond tick (tuser = 1, tdata ignored).
// Master stream: one transfer per tick (tuser = 0, held values) and one per
// frame whose footer byte is 0x00 (tuser = 1, freshly decoded values).
// Header bytes, frame bytes and bad footers produce no transfer.
// Config port: write cfg_data_i to register cfg_idx_i while cfg_we_i is high;
// only while the block is idle.
// A tick or footer goes through the input register, the decode logic and the
// result register to the master side. Throughput: one transfer per cycle
// while the master side does not stall, with all decode logic in between.
// Reset: hunting for a header, sticks at 1000, knobs at 200, switches at
// 1/1/2, link flag clear, offsets zero, timeout 1500 ms, loss limit 10.
// When the master side stalls, the result register holds, one more item is
// kept in the input register, and tready drops; items that produce no
// transfer still pass while the result waits.
`include "sbus_frame_decoder_core_macros.svh"
module sbus_frame_decoder_core
  import sfd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] data_byte
  input  logic                   s_axis_tuser_i,   // [0] func
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [15:0] stick0, [31:16] stick1, [47:32] stick2, [63:48] stick3,
  // [74:64] knob1, [85:75] knob2, [96:86] knob3, [98:97] switch_one,
  // [100:99] switch_two, [102:101] switch_three, [104:103] online_state
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o,   // [0] new_frame
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       out_fresh_q;
  sfd_res_t   out_res_q;

  logic       proc_fire;
  logic       res_valid;
  sfd_res_t   res;
  sfd_frame_t frame;

  assign proc_fire = in_valid_q && (!out_valid_q || m_axis_tready_i || !res_valid);
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_func_q <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  sfd_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (proc_fire && !in_func_q),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  sfd_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .en_i        (proc_fire),
    .tick_i      (in_func_q),
    .frame_i     (frame),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res_valid) begin
      out_res_q   <= res;
      out_fresh_q <= !in_func_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_res_q);
  assign m_axis_tuser_o  = out_fresh_q;

  `SFD_ASSERT_RST(a_reset_quiet, !rst_ni |=> (!m_axis_tvalid_o && !in_valid_q), "output valid during reset")
  `SFD_ASSERT(a_tick_report, (proc_fire && in_func_q) |=> (m_axis_tvalid_o && !m_axis_tuser_o), "tick gave no tick report")
  `SFD_ASSERT(a_frame_report, (proc_fire && res_valid && !in_func_q) |=> (m_axis_tvalid_o && m_axis_tuser_o), "good frame gave no frame result")
  `SFD_ASSERT(a_held_input, (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_byte_q)), "pending input item lost")

endmodule
